[rtl/polyline_turning_angle_unit_assert.svh]
// assertion macros shared by the checker of the turning angle unit
// depends on nothing, included by file name
`ifndef POLYLINE_TURNING_ANGLE_UNIT_ASSERT_SVH
`define POLYLINE_TURNING_ANGLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PTAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("turning angle unit: port check failed");

// next-cycle implication, disabled while reset is low
`define PTAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("turning angle unit: port check failed");

`endif

[rtl/ptau_pkg.sv]
// shared widths, constants and the cordic arctangent table of the turning angle unit
// depends on nothing
package ptau_pkg;

  localparam int unsigned PTAU_MAX_INTERVAL = 32;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned REM_W   = 6;
  localparam int unsigned DY_W    = POS_W + 1;
  localparam int unsigned DD_W    = POS_W + 2;
  localparam int unsigned DOT_W   = 30;
  localparam int unsigned CROSS_W = 26;
  localparam int unsigned CX_W    = 48;
  localparam int unsigned CZ_W    = 25;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned PRE_SHIFT    = 16;
  localparam int unsigned ROUND_SHIFT  = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd15;
  localparam logic [CNT_W-1:0] CNT_SAT   = 7'd127;

  localparam int PTAU_ANGLE_MAX = 25736;
  localparam logic signed [CZ_W-1:0] PTAU_PI_Z = 25'sd3294199;

  // atan(2^-j) in units of 2^-20 rad, rounded to nearest
  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [CZ_W-1:0] val;
    case (idx)
      4'd0:    val = 25'sd823550;
      4'd1:    val = 25'sd486170;
      4'd2:    val = 25'sd256879;
      4'd3:    val = 25'sd130396;
      4'd4:    val = 25'sd65451;
      4'd5:    val = 25'sd32757;
      4'd6:    val = 25'sd16383;
      4'd7:    val = 25'sd8192;
      4'd8:    val = 25'sd4096;
      4'd9:    val = 25'sd2048;
      4'd10:   val = 25'sd1024;
      4'd11:   val = 25'sd512;
      4'd12:   val = 25'sd256;
      4'd13:   val = 25'sd128;
      4'd14:   val = 25'sd64;
      default: val = 25'sd32;
    endcase
    return val;
  endfunction

endpackage

[rtl/ptau_window.sv]
// sample window memory: one write port, one read port with registered read data
// depends on ptau_pkg
module ptau_window import ptau_pkg::*; #(
  parameter int unsigned DEPTH  = 2 * PTAU_MAX_INTERVAL + 2,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [POS_W-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [POS_W-1:0]  rd_data_o
);

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/ptau_cordic.sv]
// iterative vectoring cordic: atan2(cross, dot) one micro-rotation per cycle
// depends on ptau_pkg
module ptau_cordic import ptau_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DOT_W-1:0]   dot_i,
  input  logic signed [CROSS_W-1:0] cross_i,
  output logic                      done_o,
  output logic signed [ANG_W-1:0]   angle_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ITER  = 3'b010,
    C_ROUND = 3'b100
  } cstate_e;

  localparam logic signed [CZ_W-1:0] QMax = CZ_W'(PTAU_ANGLE_MAX);
  localparam logic signed [CZ_W-1:0] QMin = -QMax;
  localparam logic signed [CZ_W-1:0] RoundAdd = CZ_W'(1 << (ROUND_SHIFT - 1));

  cstate_e                  state_q, state_d;
  logic [STEP_W-1:0]        step_q;
  logic signed [CX_W-1:0]   x_q, y_q;
  logic signed [CZ_W-1:0]   z_q;
  logic                     zero_q;
  logic                     done_q;
  logic signed [ANG_W-1:0]  angle_q;

  logic signed [CX_W-1:0]   x0, y0, xs, ys;
  logic signed [CZ_W-1:0]   zq, zsat;
  logic                     y_pos;

  // scale by 2^16 so the floor shifts match exactly
  assign x0 = {{(CX_W-DOT_W-PRE_SHIFT){dot_i[DOT_W-1]}}, dot_i, {PRE_SHIFT{1'b0}}};
  assign y0 = {{(CX_W-CROSS_W-PRE_SHIFT){cross_i[CROSS_W-1]}}, cross_i, {PRE_SHIFT{1'b0}}};

  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;
  assign y_pos = !y_q[CX_W-1] && (y_q != '0);

  assign zq = (z_q + RoundAdd) >>> ROUND_SHIFT;

  always_comb begin
    if (zq > QMax) begin
      zsat = QMax;
    end else if (zq < QMin) begin
      zsat = QMin;
    end else begin
      zsat = zq;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (start_i) state_d = C_ITER;
      C_ITER:  if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = C_ROUND;
      C_ROUND: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_ROUND);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          zero_q <= (dot_i == '0) && (cross_i == '0);
          step_q <= '0;
          if (dot_i[DOT_W-1]) begin
            // left half plane: rotate by pi first
            x_q <= -x0;
            y_q <= -y0;
            z_q <= cross_i[CROSS_W-1] ? -PTAU_PI_Z : PTAU_PI_Z;
          end else begin
            x_q <= x0;
            y_q <= y0;
            z_q <= '0;
          end
        end
      end
      C_ITER: begin
        if (y_pos) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_entry(step_q);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_entry(step_q);
        end
        step_q <= step_q + 1'b1;
      end
      C_ROUND: begin
        angle_q <= zero_q ? '0 : ANG_W'(zsat);
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

[rtl/polyline_turning_angle_unit.sv]
// polyline turning angle unit: top level sequencer, window memory and shared cordic
// an angle is offered after the window reads, chord differences, products and the 16-step
// cordic loop; zero angles are offered directly; a new sample is taken only once all angles
// of the last are taken; flushed zeros after the last sample leave one per cycle unless stalled
// reset: async active low; counts cleared, interval 15, window contents left unknown
module polyline_turning_angle_unit import ptau_pkg::*; #(
  parameter int unsigned MAX_INTERVAL = PTAU_MAX_INTERVAL
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sample input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [POS_W-1:0]        row_position_i,
  input  logic                    last_i,
  // angle output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ANG_W-1:0] turn_angle_o,
  output logic                    last_res_o,
  // interval register write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_curve_interval_i
);

  // window holds the newest 2*MAX_INTERVAL+2 samples, as a ring buffer
  localparam int unsigned WinDepth = 2 * MAX_INTERVAL + 2;
  localparam int unsigned AddrW    = $clog2(WinDepth);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,  // ready for a sample
    S_RD1    = 9'b000000010,  // read point i
    S_RD2    = 9'b000000100,  // read point i-I, take point i
    S_DIFF   = 9'b000001000,  // chord rises
    S_MUL1   = 9'b000010000,  // dy1*dy2
    S_MUL2   = 9'b000100000,  // dot and cross
    S_CSTART = 9'b001000000,  // kick the cordic
    S_CWAIT  = 9'b010000000,  // wait for the angle
    S_OUT    = 9'b100000000   // present angles until all are taken
  } state_e;

  state_e                      state_q, state_d;
  logic [CFG_W-1:0]            cfg_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [AddrW-1:0]            wp_q;
  logic [AddrW-1:0]            cur_wp_q;
  logic [REM_W-1:0]            rem_q;

  // per-sample payload registers
  logic [POS_W-1:0]            pos_q;
  logic                        last_q;
  logic [CFG_W-1:0]            i_q;
  logic [POS_W-1:0]            p1_q;
  logic signed [DY_W-1:0]      dy1_q, dy2_q;
  logic signed [DOT_W-1:0]     prod_q;
  logic signed [DD_W-1:0]      dd_q;
  logic signed [DOT_W-1:0]     dot_q;
  logic signed [CROSS_W-1:0]   cross_q;
  logic signed [ANG_W-1:0]     angle_q;

  logic                        in_acc, out_acc;
  logic [CFG_W-1:0]            eff_i;
  logic                        need_out, need_turn;
  logic [REM_W-1:0]            total;
  logic [CNT_W:0]              k_w, n_w, i_w, i1_w, cnt_w;

  logic [AddrW:0]              off_w, wp_w, rd_sum;
  logic [AddrW-1:0]            rd_addr;
  logic [POS_W-1:0]            rd_data;

  logic [2*CFG_W-1:0]          ii;
  logic signed [DD_W+CFG_W:0]  cprod;
  logic                        c_done;
  logic signed [ANG_W-1:0]     c_angle;

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // interval register; the user must write it only between runs of work, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_curve_interval_i;
    end
  end

  // zero acts as one, anything past the window acts as the maximum
  always_comb begin
    if (cfg_q == '0) begin
      eff_i = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_INTERVAL)) begin
      eff_i = CFG_W'(MAX_INTERVAL);
    end else begin
      eff_i = cfg_q;
    end
  end

  // how many angles this sample releases and whether the first needs the cordic
  always_comb begin
    k_w   = {1'b0, count_q};
    n_w   = k_w + 1'b1;
    i_w   = (CNT_W+1)'(eff_i);
    i1_w  = i_w + 1'b1;
    cnt_w = (n_w < i1_w) ? n_w : i1_w;
    if (last_i) begin
      need_out  = 1'b1;
      need_turn = (n_w >= ((i_w << 1) + 2'd2));
      total     = REM_W'(cnt_w);
      count_d   = '0;
    end else begin
      need_out  = (k_w >= i_w);
      need_turn = (k_w >= (i_w << 1));
      total     = REM_W'(1);
      count_d   = (count_q == CNT_SAT) ? count_q : count_q + 1'b1;
    end
  end

  // ring buffer read address: written slot minus I or 2I, wrapped
  assign off_w  = (state_q == S_RD1) ? (AddrW+1)'(i_q) : (AddrW+1)'({i_q, 1'b0});
  assign wp_w   = {1'b0, cur_wp_q};
  assign rd_sum = (wp_w >= off_w) ? (wp_w - off_w) : (wp_w + (AddrW+1)'(WinDepth) - off_w);
  assign rd_addr = rd_sum[AddrW-1:0];

  ptau_window #(
    .DEPTH  (WinDepth),
    .ADDR_W (AddrW)
  ) u_window (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (wp_q),
    .wr_data_i (row_position_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ptau_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CSTART),
    .dot_i   (dot_q),
    .cross_i (cross_q),
    .done_o  (c_done),
    .angle_o (c_angle)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && need_out) begin
          state_d = need_turn ? S_RD1 : S_OUT;
        end
      end
      S_RD1:    state_d = S_RD2;
      S_RD2:    state_d = S_DIFF;
      S_DIFF:   state_d = S_MUL1;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_CSTART;
      S_CSTART: state_d = S_CWAIT;
      S_CWAIT:  if (c_done) state_d = S_OUT;
      S_OUT:    if (out_acc && (rem_q == REM_W'(1))) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      wp_q    <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        count_q <= count_d;
        wp_q    <= (wp_q == AddrW'(WinDepth - 1)) ? '0 : wp_q + 1'b1;
        rem_q   <= total;
      end else if (out_acc) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  // datapath: one step per state
  assign ii    = i_q * i_q;
  assign cprod = dd_q * $signed({1'b0, i_q});

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pos_q    <= row_position_i;
          last_q   <= last_i;
          i_q      <= eff_i;
          cur_wp_q <= wp_q;
          angle_q  <= '0;
        end
      end
      S_RD2:  p1_q <= rd_data;
      S_DIFF: begin
        dy1_q <= $signed({1'b0, p1_q}) - $signed({1'b0, rd_data});
        dy2_q <= $signed({1'b0, pos_q}) - $signed({1'b0, p1_q});
      end
      S_MUL1: begin
        prod_q <= dy1_q * dy2_q;
        dd_q   <= DD_W'(dy2_q) - DD_W'(dy1_q);
      end
      S_MUL2: begin
        // dot = 256*I*I + dy1*dy2, cross = 16*I*(dy2-dy1)
        dot_q   <= prod_q + $signed(DOT_W'({ii, 8'b0}));
        cross_q <= CROSS_W'({cprod, 4'b0});
      end
      S_CWAIT: if (c_done) angle_q <= c_angle;
      S_OUT:   if (out_acc) angle_q <= '0;  // flushed angles are zero
      default: ;
    endcase
  end

  assign turn_angle_o = angle_q;
  assign last_res_o   = last_q && (rem_q == REM_W'(1));

endmodule

[rtl/ptau_checker.sv]
// port level checker of the turning angle unit, bound to the top level
// depends on ptau_pkg and polyline_turning_angle_unit_assert.svh
`include "polyline_turning_angle_unit_assert.svh"

module ptau_checker import ptau_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [ANG_W-1:0] turn_angle_o,
  input logic                    last_res_o
);

  // a stalled angle stays offered and unchanged
  `PTAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(turn_angle_o) && $stable(last_res_o))

  // the unit never takes a sample while an angle is pending
  `PTAU_ASSERT_NOW(a_ready_no_out, clk_i, rst_ni, !in_stall_o, !out_valid_o)

  // once the final angle of a run is taken nothing is left pending
  `PTAU_ASSERT_NEXT(a_last_drains, clk_i, rst_ni, out_valid_o && !out_stall_i && last_res_o, !out_valid_o)

  // angles stay within minus pi to pi
  `PTAU_ASSERT_NOW(a_angle_range, clk_i, rst_ni, out_valid_o, ($signed(turn_angle_o) <= PTAU_ANGLE_MAX) && ($signed(turn_angle_o) >= -PTAU_ANGLE_MAX))

endmodule

bind polyline_turning_angle_unit ptau_checker u_ptau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .turn_angle_o (turn_angle_o),
  .last_res_o   (last_res_o)
);

[verif/polyline_turning_angle_checker.sv]
// checker for the polyline turning angle unit: predicts angles from the observed transactions
// depends on ptau_pkg for port widths and angle limits
module polyline_turning_angle_checker import ptau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [POS_W-1:0]        row_position_i,
  input  logic                    last_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [ANG_W-1:0] turn_angle_i,
  input  logic                    last_res_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_W-1:0]        cfg_curve_interval_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam int unsigned HISTORY_DEPTH = 2 * PTAU_MAX_INTERVAL + 2;
  localparam int unsigned RUN_SAT       = 127;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic                    last;
  } angle_exp_t;

  angle_exp_t     expected_angles[$];
  logic [POS_W-1:0] row_history[HISTORY_DEPTH];
  logic [CFG_W-1:0] interval_reg;
  int unsigned      run_samples;

  function automatic longint atan_q20(input int unsigned step);
    case (step)
      0:       return 823550;
      1:       return 486170;
      2:       return 256879;
      3:       return 130396;
      4:       return 65451;
      5:       return 32757;
      6:       return 16383;
      7:       return 8192;
      8:       return 4096;
      9:       return 2048;
      10:      return 1024;
      11:      return 512;
      12:      return 256;
      13:      return 128;
      14:      return 64;
      default: return 32;
    endcase
  endfunction

  function automatic int unsigned chord_span();
    if (interval_reg == '0) return 1;
    if (interval_reg > PTAU_MAX_INTERVAL) return PTAU_MAX_INTERVAL;
    return interval_reg;
  endfunction

  // vectoring cordic on (dot, cross) of the two chords meeting at the middle point
  function automatic logic signed [ANG_W-1:0] chord_turn(input int unsigned span);
    longint rise_in, rise_out, x, y, z, xs, ys, q, s;
    s        = longint'(span);
    rise_in  = longint'(row_history[span]) - longint'(row_history[2*span]);
    rise_out = longint'(row_history[0]) - longint'(row_history[span]);
    x = (256 * s * s + rise_in * rise_out) * 65536;
    y = (16 * s * (rise_out - rise_in)) * 65536;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane: rotate by pi first
    if (x < 0) begin
      z = (y >= 0) ? longint'(PTAU_PI_Z) : -longint'(PTAU_PI_Z);
      x = -x;
      y = -y;
    end
    for (int j = 0; j < 16; j++) begin
      xs = x >>> j;
      ys = y >>> j;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q20(j);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q20(j);
      end
    end
    q = (z + 64) >>> 7;
    if (q > PTAU_ANGLE_MAX) q = PTAU_ANGLE_MAX;
    if (q < -PTAU_ANGLE_MAX) q = -PTAU_ANGLE_MAX;
    return q[ANG_W-1:0];
  endfunction

  task automatic push_angle(input logic signed [ANG_W-1:0] a, input logic l);
    angle_exp_t e;
    e.angle = a;
    e.last  = l;
    expected_angles.insert(expected_angles.size(), e);
  endtask

  task automatic take_sample(input logic [POS_W-1:0] pos, input logic lst);
    int unsigned span, seen, n, cnt;
    span = chord_span();
    seen = run_samples;
    for (int j = HISTORY_DEPTH - 1; j > 0; j--) row_history[j] = row_history[j-1];
    row_history[0] = pos;
    if (!lst) begin
      if (seen >= span) push_angle((seen >= 2 * span) ? chord_turn(span) : '0, 1'b0);
      run_samples = (seen < RUN_SAT) ? seen + 1 : RUN_SAT;
    end else begin
      // flush the tail of the run, the first one may still be a real angle
      n   = seen + 1;
      cnt = (n < span + 1) ? n : span + 1;
      for (int t = 0; t < cnt; t++) begin
        push_angle((t == 0 && n >= 2 * span + 2) ? chord_turn(span) : '0, t + 1 == cnt);
      end
      run_samples = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("mismatch on %s of angle %0d: expected %0d, got %0d",
               what, checked_o, want, got);
    end
  endtask

  task automatic compare_angle(input logic signed [ANG_W-1:0] a, input logic l);
    angle_exp_t e;
    if (expected_angles.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected angle %0d with nothing pending", a);
    end else begin
      e = expected_angles.pop_front();
      if (a !== e.angle) report_mismatch("turn_angle", e.angle, a);
      if (l !== e.last) report_mismatch("last_res", e.last, l);
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_angles.delete();
      for (int j = 0; j < HISTORY_DEPTH; j++) row_history[j] = '0;
      interval_reg = CFG_RESET;
      run_samples  = 0;
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) interval_reg = cfg_curve_interval_i;
      if (in_valid_i && !in_stall_i) take_sample(row_position_i, last_i);
      if (out_valid_i && !out_stall_i) compare_angle(turn_angle_i, last_res_i);
      pending_o = expected_angles.size();
    end
  end

endmodule

[verif/polyline_turning_angle_unit_test.sv]
// testbench top for the polyline turning angle unit: clock, reset, stimulus and verdict
// depends on ptau_pkg, polyline_turning_angle_unit and polyline_turning_angle_checker
module polyline_turning_angle_unit_test;
  import ptau_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  // a margin beyond the sample-to-angle path of the block
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int POS_MAX       = (1 << POS_W) - 1;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  logic [POS_W-1:0]        row_position;
  logic                    last_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ANG_W-1:0] turn_angle;
  logic                    last_res;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;

  int angle_errors;
  int angles_pending;
  int angles_checked;

  // idle percentages for the sender and the receiver, changed per phase
  int send_gap_pct;
  int recv_gap_pct;
  // toggling this asks the receiver for one long hold-off
  logic hold_go;
  logic hold_seen;
  int   hold_left;

  int samples_sent;
  int runs_sent;
  int interval_writes;
  int cur_span;
  int cycles;

  polyline_turning_angle_unit i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .row_position_i       (row_position),
    .last_i               (last_sample),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .turn_angle_o         (turn_angle),
    .last_res_o           (last_res),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_curve_interval_i (cfg_data)
  );

  // watches all three channels and keeps the expected angles
  polyline_turning_angle_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .row_position_i       (row_position),
    .last_i               (last_sample),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .turn_angle_i         (turn_angle),
    .last_res_i           (last_res),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_curve_interval_i (cfg_data),
    .fail_count_o         (angle_errors),
    .pending_o            (angles_pending),
    .checked_o            (angles_checked)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // cycle counter, ends a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d angles pending", cycles, angles_pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off counted here when asked for
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  function automatic int span_of(input int value);
    if (value == 0) return 1;
    if (value > PTAU_MAX_INTERVAL) return PTAU_MAX_INTERVAL;
    return value;
  endfunction

  // one sample transaction; entered and left at a falling edge
  task automatic send_sample(input int pos, input logic lst);
    logic taken;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    row_position <= pos[POS_W-1:0];
    last_sample  <= lst;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall;
    end
    @(negedge clk_i);
    samples_sent++;
    if (lst) runs_sent++;
  endtask

  // block goes idle: no offer, all angles back, and a margin for work still in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (angles_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_interval(input int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    cur_span = span_of(value);
    interval_writes++;
  endtask

  // one run of row positions; switch_at > 0 rewrites the interval after that many samples
  task automatic send_run(input int len, input int switch_at, input int switch_to);
    int style, pos, step, v;
    style = $urandom_range(0, 9);
    step  = (style < 6) ? $urandom_range(1, 64) : $urandom_range(1000, 8000);
    pos   = $urandom_range(0, POS_MAX);
    for (int i = 0; i < len; i++) begin
      if (style < 8) begin
        // random walk, gentle or steep
        pos = pos + $urandom_range(0, 2 * step) - step;
        if (pos < 0) pos = 0;
        if (pos > POS_MAX) pos = POS_MAX;
        v = pos;
      end else if (style == 8) begin
        v = $urandom_range(0, POS_MAX);
      end else begin
        v = $urandom_range(0, 1) ? POS_MAX : 0;
      end
      send_sample(v, i == len - 1);
      if (switch_at > 0 && i + 1 == switch_at) write_interval(switch_to);
    end
  endtask

  // mostly runs long enough for real angles, some short ones that only flush zeros
  task automatic random_phase(input int quota);
    int start, pick, len;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      if ($urandom_range(0, 2) == 0) write_interval($urandom_range(0, 8));
      pick = $urandom_range(0, 9);
      if (pick < 7) len = 2 * cur_span + 2 + $urandom_range(0, 10);
      else if (pick < 9) len = $urandom_range(1, 2 * cur_span + 1);
      else len = $urandom_range(1, 3);
      send_run(len, 0, 0);
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    row_position = '0;
    last_sample  = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_go      = 1'b0;
    hold_seen    = 1'b0;
    hold_left    = 0;
    cycles       = 0;
    samples_sent = 0;
    runs_sent    = 0;
    interval_writes = 0;
    cur_span     = span_of(CFG_RESET);
    send_gap_pct = 28;
    recv_gap_pct = 79;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset interval, run shorter than interval plus one, zeros only
    send_sample(POS_MAX, 1'b0);
    send_sample(0, 1'b1);

    // interval 1: full-scale zigzags push the dot product negative, both turn signs
    write_interval(1);
    send_sample(0, 1'b0);
    send_sample(POS_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(POS_MAX, 1'b1);
    send_sample(POS_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(POS_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(POS_MAX, 1'b1);
    // single-sample run
    send_sample(8191, 1'b1);
    // one short of the minimum length for a real angle
    send_sample(100, 1'b0);
    send_sample(200, 1'b0);
    send_sample(300, 1'b1);
    // flat line, zero angle
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b1);

    // interval 0 behaves as 1; alternating bit patterns
    write_interval(0);
    send_sample(16'h2AAA, 1'b0);
    send_sample(16'h1555, 1'b0);
    send_sample(POS_MAX, 1'b0);
    send_sample(0, 1'b1);

    // phase 1: sender idles a little, receiver a lot
    write_interval(2);
    random_phase(25);
    // 63 saturates to the widest interval, run exactly long enough for one angle
    write_interval(63);
    send_run(2 * PTAU_MAX_INTERVAL + 2, 0, 0);

    // phase 2: the other way round
    send_gap_pct = 79;
    recv_gap_pct = 28;
    // widest interval, run one short: every result is a zero, the flush is the longest
    write_interval(PTAU_MAX_INTERVAL);
    send_run(2 * PTAU_MAX_INTERVAL + 1, 0, 0);
    random_phase(25);

    // phase 3: no idling; long receiver hold-off so the block backs up into its input
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_interval(1);
    hold_go = ~hold_go;
    send_run(40, 0, 0);
    // interval changed mid run while the block is idle; the window is fully written by now
    write_interval(3);
    send_run(30, 15, 5);
    random_phase(25);

    wait_drained();

    $display("covered %0d samples in %0d runs over %0d interval writes (0, 1, 32, 63 included)",
             samples_sent, runs_sent, interval_writes);
    $display("compared %0d angles, %0d failures, %0d left unanswered",
             angles_checked, angle_errors, angles_pending);
    if (angle_errors == 0 && angles_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
